>>> hw/rtl/snfcs_pkg.sv
package snfcs_pkg;

  // Page geometry (power of two)
  localparam int PAGE_BYTES = 256;
  localparam int PAGE_LOG2  = $clog2(PAGE_BYTES);
  localparam int PAGES_W    = 16 - PAGE_LOG2;

  // Result list depth per transaction
  localparam int RES_MAX   = 10;
  localparam int RES_IDX_W = $clog2(RES_MAX + 1);

  // Request modes
  localparam logic [2:0] MODE_READ    = 3'd0;
  localparam logic [2:0] MODE_PROG    = 3'd1;
  localparam logic [2:0] MODE_ERASE   = 3'd2;
  localparam logic [2:0] MODE_PAYLOAD = 3'd3;
  localparam logic [2:0] MODE_FLASH   = 3'd4;

  // Flash opcodes
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_PP    = 8'h02;
  localparam logic [7:0] CMD_SE    = 8'hD8;

  // Status register bits
  localparam int SR_BUSY = 0;
  localparam int SR_WEL  = 1;

  // Result codes
  localparam logic RC_OK      = 1'b0;
  localparam logic RC_BAD_LEN = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_STATUS,
    PH_RDATA,
    PH_WDATA,
    PH_EPOLL
  } phase_t;

  typedef enum logic [1:0] {
    OP_READ,
    OP_PROG,
    OP_ERASE
  } op_t;

  typedef enum logic [2:0] {
    ACT_SEND,
    ACT_SLOT,
    ACT_DESEL,
    ACT_HOST,
    ACT_PAUSE,
    ACT_DONE
  } act_t;

  typedef struct packed {
    act_t       act;
    logic [7:0] data;
    logic       code;
  } entry_t;

  function automatic entry_t mk(act_t act, logic [7:0] data, logic code);
    entry_t e;
    e.act  = act;
    e.data = data;
    e.code = code;
    return e;
  endfunction

endpackage

>>> hw/rtl/snfcs_in_if.sv
interface snfcs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] page_address;
  logic [15:0] byte_count;
  logic [7:0]  sector;
  logic        do_erase;
  logic [7:0]  data_byte;

  modport source (
    output valid, mode, page_address, byte_count, sector, do_erase, data_byte,
    input  ready
  );
  modport sink (
    input  valid, mode, page_address, byte_count, sector, do_erase, data_byte,
    output ready
  );
endinterface

>>> hw/rtl/snfcs_out_if.sv
interface snfcs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] bus_byte;
  logic [7:0] host_byte;
  logic       result_code;
  logic       last;

  modport source (
    output valid, action, bus_byte, host_byte, result_code, last,
    input  ready
  );
  modport sink (
    input  valid, action, bus_byte, host_byte, result_code, last,
    output ready
  );
endinterface

>>> hw/rtl/spi_nor_flash_command_sequencer.sv
// Channel   Dir  Payload
// -------   ---  ---------------------------------------------------------
// in_ch     in   mode, page_address, byte_count, sector, do_erase, data_byte
// out_ch    out  action, bus_byte, host_byte, result_code, last
// cfg       in   cfg_wr_en, cfg_wr_data (fast_read)
//
// A request transaction is decoded in the cycle it is accepted; its result
// list (up to 10 entries) is registered and drained one entry per cycle
// while the output is ready; the next request is taken in the cycle the last
// result leaves, or at once if a request produced no results.
// Reset (rst, synchronous) returns to idle, clears fast_read and the list.
// Output stalls hold the list and backpressure the request channel.
module spi_nor_flash_command_sequencer (
  input  logic                clk,
  input  logic                rst,
  snfcs_in_if.sink            in_ch,
  snfcs_out_if.source         out_ch,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  // State
  snfcs_pkg::phase_t                   phase, phase_next;
  snfcs_pkg::op_t                      operation, operation_next;
  logic [23:0]                         flash_address, flash_address_next;
  logic [snfcs_pkg::PAGES_W-1:0]       pages_remaining, pages_remaining_next;
  logic [snfcs_pkg::PAGE_LOG2-1:0]     byte_in_page, byte_in_page_next;
  logic                                status_bytes_seen, status_bytes_seen_next;
  logic [1:0]                          saved_status, saved_status_next;
  logic                                fast_read;

  // Result list
  snfcs_pkg::entry_t                   lst [snfcs_pkg::RES_MAX];
  snfcs_pkg::entry_t                   lst_next [snfcs_pkg::RES_MAX];
  logic [snfcs_pkg::RES_IDX_W-1:0]     n, idx, res_cnt_next;

  // Decode
  logic        acc, drain, last_out;
  logic        ev_start_rw, ev_erase, ev_stat1, ev_stat2, ev_rdata, ev_wdata, ev_poll;
  logic        cnt_zero, cnt_partial, start_ok, stat_ok, poll_busy;
  logic        page_done, last_page, page_start, cmd_prog;
  logic        want_status, want_cmd;
  logic [23:0] start_addr, next_addr, cmd_addr;

  // Handshakes
  assign drain       = out_ch.valid && out_ch.ready;
  assign last_out    = (idx == n - snfcs_pkg::RES_IDX_W'(1));
  assign in_ch.ready = (n == '0) || (drain && last_out);
  assign acc         = in_ch.valid && in_ch.ready;

  // Classify the incoming transaction against the current phase
  assign ev_start_rw = acc && (phase == snfcs_pkg::PH_IDLE) &&
                       ((in_ch.mode == snfcs_pkg::MODE_READ) ||
                        (in_ch.mode == snfcs_pkg::MODE_PROG));
  assign ev_erase    = acc && (phase == snfcs_pkg::PH_IDLE) &&
                       (in_ch.mode == snfcs_pkg::MODE_ERASE);
  assign ev_stat1    = acc && (phase == snfcs_pkg::PH_STATUS) &&
                       (in_ch.mode == snfcs_pkg::MODE_FLASH) && !status_bytes_seen;
  assign ev_stat2    = acc && (phase == snfcs_pkg::PH_STATUS) &&
                       (in_ch.mode == snfcs_pkg::MODE_FLASH) && status_bytes_seen;
  assign ev_rdata    = acc && (phase == snfcs_pkg::PH_RDATA) &&
                       (in_ch.mode == snfcs_pkg::MODE_FLASH);
  assign ev_wdata    = acc && (phase == snfcs_pkg::PH_WDATA) &&
                       (in_ch.mode == snfcs_pkg::MODE_PAYLOAD);
  assign ev_poll     = acc && (phase == snfcs_pkg::PH_EPOLL) &&
                       (in_ch.mode == snfcs_pkg::MODE_FLASH);

  assign cnt_zero    = (in_ch.byte_count == 16'd0);
  assign cnt_partial = |in_ch.byte_count[snfcs_pkg::PAGE_LOG2-1:0];
  assign start_ok    = ev_start_rw && !cnt_zero && !cnt_partial;
  assign stat_ok     = !saved_status[snfcs_pkg::SR_BUSY] && saved_status[snfcs_pkg::SR_WEL];
  assign poll_busy   = in_ch.data_byte[snfcs_pkg::SR_BUSY];

  // Page boundary and next-page decision
  assign page_done  = (ev_rdata || ev_wdata) && (byte_in_page == '1);
  assign last_page  = (pages_remaining == snfcs_pkg::PAGES_W'(1));
  assign page_start = start_ok || (page_done && !last_page);
  assign cmd_prog   = ev_start_rw ? (in_ch.mode == snfcs_pkg::MODE_PROG)
                                  : (operation == snfcs_pkg::OP_PROG);

  assign want_status = (page_start && (cmd_prog || !fast_read)) || (ev_stat2 && !stat_ok);
  assign want_cmd    = (page_start && !cmd_prog && fast_read) || (ev_stat2 && stat_ok);

  assign start_addr = 24'({in_ch.page_address, {snfcs_pkg::PAGE_LOG2{1'b0}}});
  assign next_addr  = flash_address + 24'(snfcs_pkg::PAGE_BYTES);
  assign cmd_addr   = ev_start_rw ? start_addr : (page_done ? next_addr : flash_address);

  // Next state
  always_comb begin
    phase_next             = phase;
    operation_next         = operation;
    flash_address_next     = flash_address;
    pages_remaining_next   = pages_remaining;
    byte_in_page_next      = byte_in_page;
    status_bytes_seen_next = status_bytes_seen;
    saved_status_next      = saved_status;

    if (start_ok) begin
      operation_next       = cmd_prog ? snfcs_pkg::OP_PROG : snfcs_pkg::OP_READ;
      flash_address_next   = start_addr;
      pages_remaining_next = snfcs_pkg::PAGES_W'(in_ch.byte_count >> snfcs_pkg::PAGE_LOG2);
    end
    if (ev_erase) begin
      operation_next = snfcs_pkg::OP_ERASE;
      phase_next     = snfcs_pkg::PH_EPOLL;
    end
    if (ev_stat1) begin
      saved_status_next      = in_ch.data_byte[1:0];
      status_bytes_seen_next = 1'b1;
    end
    if (ev_rdata || ev_wdata) begin
      byte_in_page_next = byte_in_page + snfcs_pkg::PAGE_LOG2'(1);
    end
    if (page_done) begin
      flash_address_next   = next_addr;
      pages_remaining_next = pages_remaining - snfcs_pkg::PAGES_W'(1);
      if (last_page) begin
        phase_next = snfcs_pkg::PH_IDLE;
      end
    end
    if (ev_poll && !poll_busy) begin
      phase_next = snfcs_pkg::PH_IDLE;
    end
    if (want_status) begin
      status_bytes_seen_next = 1'b0;
      phase_next             = snfcs_pkg::PH_STATUS;
    end
    if (want_cmd) begin
      byte_in_page_next = '0;
      phase_next        = cmd_prog ? snfcs_pkg::PH_WDATA : snfcs_pkg::PH_RDATA;
    end
  end

  // Result list for the accepted transaction
  always_comb begin
    for (int i = 0; i < snfcs_pkg::RES_MAX; i++) begin
      lst_next[i] = snfcs_pkg::mk(snfcs_pkg::ACT_SEND, 8'h00, 1'b0);
    end
    res_cnt_next = '0;

    if (ev_start_rw && (cnt_zero || cnt_partial)) begin
      lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_DONE, 8'h00,
                                             cnt_zero ? snfcs_pkg::RC_OK
                                                      : snfcs_pkg::RC_BAD_LEN);
      res_cnt_next = res_cnt_next + 1'b1;
    end
    if (ev_erase) begin
      lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_WREN, 1'b0);
      res_cnt_next = res_cnt_next + 1'b1;
      lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_DESEL, 8'h00, 1'b0);
      res_cnt_next = res_cnt_next + 1'b1;
      if (in_ch.do_erase) begin
        lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_SE, 1'b0);
        res_cnt_next = res_cnt_next + 1'b1;
        lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_SEND, in_ch.sector, 1'b0);
        res_cnt_next = res_cnt_next + 1'b1;
        lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_SEND, 8'h00, 1'b0);
        res_cnt_next = res_cnt_next + 1'b1;
        lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_SEND, 8'h00, 1'b0);
        res_cnt_next = res_cnt_next + 1'b1;
        lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_DESEL, 8'h00, 1'b0);
        res_cnt_next = res_cnt_next + 1'b1;
      end
      lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_RDSR, 1'b0);
      res_cnt_next = res_cnt_next + 1'b1;
      lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_SLOT, 8'h00, 1'b0);
      res_cnt_next = res_cnt_next + 1'b1;
    end
    if (ev_stat1) begin
      lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_SLOT, 8'h00, 1'b0);
      res_cnt_next = res_cnt_next + 1'b1;
    end
    if (ev_stat2 || ev_poll) begin
      lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_DESEL, 8'h00, 1'b0);
      res_cnt_next = res_cnt_next + 1'b1;
    end
    if (ev_poll) begin
      if (poll_busy) begin
        lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_RDSR, 1'b0);
        res_cnt_next = res_cnt_next + 1'b1;
        lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_SLOT, 8'h00, 1'b0);
        res_cnt_next = res_cnt_next + 1'b1;
      end else begin
        lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_DONE, 8'h00, snfcs_pkg::RC_OK);
        res_cnt_next = res_cnt_next + 1'b1;
      end
    end
    if (ev_rdata) begin
      lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_HOST, in_ch.data_byte, 1'b0);
      res_cnt_next = res_cnt_next + 1'b1;
      if (!page_done) begin
        lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_SLOT, 8'h00, 1'b0);
        res_cnt_next = res_cnt_next + 1'b1;
      end
    end
    if (ev_wdata) begin
      lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_SEND, in_ch.data_byte, 1'b0);
      res_cnt_next = res_cnt_next + 1'b1;
    end
    // Close the page: deselect, optional pause, finish on the last page
    if (page_done) begin
      lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_DESEL, 8'h00, 1'b0);
      res_cnt_next = res_cnt_next + 1'b1;
      if (!fast_read) begin
        lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_PAUSE, 8'h00, 1'b0);
        res_cnt_next = res_cnt_next + 1'b1;
      end
      if (last_page) begin
        lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_DONE, 8'h00, snfcs_pkg::RC_OK);
        res_cnt_next = res_cnt_next + 1'b1;
      end
    end
    // Write enable plus status read
    if (want_status) begin
      lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_WREN, 1'b0);
      res_cnt_next = res_cnt_next + 1'b1;
      lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_DESEL, 8'h00, 1'b0);
      res_cnt_next = res_cnt_next + 1'b1;
      lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_SEND, snfcs_pkg::CMD_RDSR, 1'b0);
      res_cnt_next = res_cnt_next + 1'b1;
      lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_SLOT, 8'h00, 1'b0);
      res_cnt_next = res_cnt_next + 1'b1;
    end
    // Page command with three address bytes, plus a slot for reads
    if (want_cmd) begin
      lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_SEND,
                                             cmd_prog ? snfcs_pkg::CMD_PP : snfcs_pkg::CMD_READ,
                                             1'b0);
      res_cnt_next = res_cnt_next + 1'b1;
      lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_SEND, cmd_addr[23:16], 1'b0);
      res_cnt_next = res_cnt_next + 1'b1;
      lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_SEND, cmd_addr[15:8], 1'b0);
      res_cnt_next = res_cnt_next + 1'b1;
      lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_SEND, cmd_addr[7:0], 1'b0);
      res_cnt_next = res_cnt_next + 1'b1;
      if (!cmd_prog) begin
        lst_next[res_cnt_next] = snfcs_pkg::mk(snfcs_pkg::ACT_SLOT, 8'h00, 1'b0);
        res_cnt_next = res_cnt_next + 1'b1;
      end
    end
  end

  // Sequencer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= snfcs_pkg::PH_IDLE;
      operation         <= snfcs_pkg::OP_READ;
      flash_address     <= '0;
      pages_remaining   <= '0;
      byte_in_page      <= '0;
      status_bytes_seen <= 1'b0;
      saved_status      <= '0;
    end else if (acc) begin
      phase             <= phase_next;
      operation         <= operation_next;
      flash_address     <= flash_address_next;
      pages_remaining   <= pages_remaining_next;
      byte_in_page      <= byte_in_page_next;
      status_bytes_seen <= status_bytes_seen_next;
      saved_status      <= saved_status_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_read <= 1'b0;
    end else if (cfg_wr_en) begin
      fast_read <= cfg_wr_data;
    end
  end

  // Result list count and read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      n   <= '0;
      idx <= '0;
    end else if (acc) begin
      n   <= res_cnt_next;
      idx <= '0;
    end else if (drain) begin
      if (last_out) begin
        n   <= '0;
        idx <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  // Result list payload
  always_ff @(posedge clk) begin
    if (acc) begin
      lst <= lst_next;
    end
  end

  // Drive the result channel
  assign out_ch.valid       = (n != '0);
  assign out_ch.action      = lst[idx].act;
  assign out_ch.bus_byte    = (lst[idx].act == snfcs_pkg::ACT_SEND) ? lst[idx].data : 8'h00;
  assign out_ch.host_byte   = (lst[idx].act == snfcs_pkg::ACT_HOST) ? lst[idx].data : 8'h00;
  assign out_ch.result_code = lst[idx].code;
  assign out_ch.last        = last_out;

  // Checks
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (idx < n))
    else $error("result pointer beyond list");

  a_done_is_idle: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (lst[idx].act == snfcs_pkg::ACT_DONE)) |-> (phase == snfcs_pkg::PH_IDLE))
    else $error("finish reported while a request is still active");

  a_pages_live: assert property (@(posedge clk) disable iff (rst)
    ((phase == snfcs_pkg::PH_RDATA) || (phase == snfcs_pkg::PH_WDATA) ||
     (phase == snfcs_pkg::PH_STATUS)) |-> (pages_remaining != '0))
    else $error("page transfer active with no pages left");

endmodule

>>> bench/spi_nor_flash_command_sequencer_tb.sv
`timescale 1ns / 100ps

module spi_nor_flash_command_sequencer_tb;
  import snfcs_pkg::*;

  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_PAD    = 16;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int PHASE_BUDGET = 80;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] page_address;
    logic [15:0] byte_count;
    logic [7:0]  sector;
    logic        do_erase;
    logic [7:0]  data_byte;
  } flash_req_t;

  typedef struct packed {
    act_t       action;
    logic [7:0] bus_byte;
    logic [7:0] host_byte;
    logic       result_code;
    logic       last;
  } flash_action_t;

  // Flash command sequence predictor plus the queue of actions still owed
  class flash_seq_scoreboard;
    bit            fast_read;
    phase_t        phase;
    op_t           op;
    logic [23:0]   flash_addr;
    int unsigned   pages_left;
    int unsigned   byte_idx;
    bit            status_seen;
    logic [7:0]    held_status;
    flash_action_t pending_actions[$];
    flash_action_t step_actions[$];
    int            errors;

    function new();
      fast_read   = 1'b0;
      phase       = PH_IDLE;
      op          = OP_READ;
      flash_addr  = '0;
      pages_left  = 0;
      byte_idx    = 0;
      status_seen = 1'b0;
      held_status = '0;
      errors      = 0;
    endfunction

    function void log_error(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void add(act_t a, logic [7:0] bus, logic [7:0] host, logic code);
      flash_action_t e;
      if (step_actions.size() >= RES_MAX) return;
      e.action      = a;
      e.bus_byte    = bus;
      e.host_byte   = host;
      e.result_code = code;
      e.last        = 1'b0;
      step_actions.push_back(e);
    endfunction

    function void finish_req(logic code);
      add(ACT_DONE, 8'h00, 8'h00, code);
      phase = PH_IDLE;
    endfunction

    // Write enable, then read status into a fresh two-byte slot pair
    function void start_status();
      add(ACT_SEND, CMD_WREN, 8'h00, 1'b0);
      add(ACT_DESEL, 8'h00, 8'h00, 1'b0);
      add(ACT_SEND, CMD_RDSR, 8'h00, 1'b0);
      add(ACT_SLOT, 8'h00, 8'h00, 1'b0);
      status_seen = 1'b0;
      phase = PH_STATUS;
    endfunction

    function void open_page();
      add(ACT_SEND, (op == OP_PROG) ? CMD_PP : CMD_READ, 8'h00, 1'b0);
      add(ACT_SEND, flash_addr[23:16], 8'h00, 1'b0);
      add(ACT_SEND, flash_addr[15:8], 8'h00, 1'b0);
      add(ACT_SEND, flash_addr[7:0], 8'h00, 1'b0);
      byte_idx = 0;
      if (op == OP_PROG) begin
        phase = PH_WDATA;
      end else begin
        add(ACT_SLOT, 8'h00, 8'h00, 1'b0);
        phase = PH_RDATA;
      end
    endfunction

    function void next_page();
      if (op == OP_PROG || !fast_read) start_status();
      else open_page();
    endfunction

    // Deselect, advance to the next page, pause unless fast reads are on, then finish or go on
    function void close_page();
      add(ACT_DESEL, 8'h00, 8'h00, 1'b0);
      flash_addr = flash_addr + 24'(PAGE_BYTES);
      pages_left--;
      if (!fast_read) add(ACT_PAUSE, 8'h00, 8'h00, 1'b0);
      if (pages_left == 0) finish_req(RC_OK);
      else next_page();
    endfunction

    function int note_request(flash_req_t r);
      step_actions.delete();
      case (phase)
        PH_IDLE: begin
          if (r.mode == MODE_READ || r.mode == MODE_PROG) begin
            if (r.byte_count == 0) begin
              finish_req(RC_OK);
            end else if (r.byte_count % PAGE_BYTES != 0) begin
              finish_req(RC_BAD_LEN);
            end else begin
              op = (r.mode == MODE_READ) ? OP_READ : OP_PROG;
              flash_addr = 24'(32'(r.page_address) * PAGE_BYTES);
              pages_left = r.byte_count / PAGE_BYTES;
              next_page();
            end
          end else if (r.mode == MODE_ERASE) begin
            op = OP_ERASE;
            add(ACT_SEND, CMD_WREN, 8'h00, 1'b0);
            add(ACT_DESEL, 8'h00, 8'h00, 1'b0);
            if (r.do_erase) begin
              add(ACT_SEND, CMD_SE, 8'h00, 1'b0);
              add(ACT_SEND, r.sector, 8'h00, 1'b0);
              add(ACT_SEND, 8'h00, 8'h00, 1'b0);
              add(ACT_SEND, 8'h00, 8'h00, 1'b0);
              add(ACT_DESEL, 8'h00, 8'h00, 1'b0);
            end
            add(ACT_SEND, CMD_RDSR, 8'h00, 1'b0);
            add(ACT_SLOT, 8'h00, 8'h00, 1'b0);
            phase = PH_EPOLL;
          end
        end
        PH_STATUS: begin
          if (r.mode == MODE_FLASH) begin
            if (!status_seen) begin
              held_status = r.data_byte;
              status_seen = 1'b1;
              add(ACT_SLOT, 8'h00, 8'h00, 1'b0);
            end else begin
              add(ACT_DESEL, 8'h00, 8'h00, 1'b0);
              if (held_status[SR_BUSY] || !held_status[SR_WEL]) start_status();
              else open_page();
            end
          end
        end
        PH_RDATA: begin
          if (r.mode == MODE_FLASH) begin
            add(ACT_HOST, 8'h00, r.data_byte, 1'b0);
            byte_idx++;
            if (byte_idx >= PAGE_BYTES) close_page();
            else add(ACT_SLOT, 8'h00, 8'h00, 1'b0);
          end
        end
        PH_WDATA: begin
          if (r.mode == MODE_PAYLOAD) begin
            add(ACT_SEND, r.data_byte, 8'h00, 1'b0);
            byte_idx++;
            if (byte_idx >= PAGE_BYTES) close_page();
          end
        end
        PH_EPOLL: begin
          if (r.mode == MODE_FLASH) begin
            held_status = r.data_byte;
            add(ACT_DESEL, 8'h00, 8'h00, 1'b0);
            if (r.data_byte[SR_BUSY]) begin
              add(ACT_SEND, CMD_RDSR, 8'h00, 1'b0);
              add(ACT_SLOT, 8'h00, 8'h00, 1'b0);
            end else begin
              finish_req(RC_OK);
            end
          end
        end
        default: ;
      endcase
      if (step_actions.size() > 0) step_actions[step_actions.size() - 1].last = 1'b1;
      foreach (step_actions[i]) pending_actions.push_back(step_actions[i]);
      return step_actions.size();
    endfunction

    function void check_result(flash_action_t got);
      flash_action_t exp;
      if (pending_actions.size() == 0) begin
        log_error($sformatf("unexpected action: act=%0d bus=%02h host=%02h code=%0d last=%0d",
                            got.action, got.bus_byte, got.host_byte, got.result_code,
                            got.last));
        return;
      end
      exp = pending_actions.pop_front();
      if (got.action !== exp.action || got.bus_byte !== exp.bus_byte ||
          got.host_byte !== exp.host_byte || got.result_code !== exp.result_code ||
          got.last !== exp.last) begin
        log_error($sformatf({"action mismatch: expected act=%0d bus=%02h host=%02h code=%0d ",
                             "last=%0d, got act=%0d bus=%02h host=%02h code=%0d last=%0d"},
                            exp.action, exp.bus_byte, exp.host_byte, exp.result_code,
                            exp.last, got.action, got.bus_byte, got.host_byte,
                            got.result_code, got.last));
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  snfcs_in_if  in_if();
  snfcs_out_if out_if();

  flash_seq_scoreboard sb = new();

  bit quiet;
  bit hold_off_req;
  int n_items;

  spi_nor_flash_command_sequencer dut (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("** spi_nor_flash_command_sequencer: FAILED **");
    $finish;
  end

  // Check every action that leaves the block
  always @(posedge clk) begin
    flash_action_t got;
    if (!rst && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.action      = act_t'(out_if.action);
      got.bus_byte    = out_if.bus_byte;
      got.host_byte   = out_if.host_byte;
      got.result_code = out_if.result_code;
      got.last        = out_if.last;
      sb.check_result(got);
    end
  end

  // Drive output ready: random stall bursts, one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_if.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic flash_req_t rand_req();
    flash_req_t r;
    r.mode         = 3'($urandom_range(0, 7));
    r.page_address = 16'($urandom);
    r.byte_count   = 16'($urandom);
    r.sector       = 8'($urandom);
    r.do_erase     = 1'($urandom);
    r.data_byte    = 8'($urandom);
    return r;
  endfunction

  function automatic flash_req_t req_of(logic [2:0] mode, logic [15:0] page,
                                        logic [15:0] count, logic [7:0] sector,
                                        logic do_erase, logic [7:0] data);
    flash_req_t r;
    r.mode         = mode;
    r.page_address = page;
    r.byte_count   = count;
    r.sector       = sector;
    r.do_erase     = do_erase;
    r.data_byte    = data;
    return r;
  endfunction

  // Offer one request transaction, hold it until taken, then predict it
  task automatic put_request(input flash_req_t r);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.mode         <= r.mode;
    in_if.page_address <= r.page_address;
    in_if.byte_count   <= r.byte_count;
    in_if.sector       <= r.sector;
    in_if.do_erase     <= r.do_erase;
    in_if.data_byte    <= r.data_byte;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (sb.note_request(r) > 0) n_items++;
  endtask

  // Feed well-formed bytes until the sequencer is idle, with some strays mixed in
  task automatic drive_until_idle();
    flash_req_t r;
    while (sb.phase != PH_IDLE) begin
      r = rand_req();
      if ($urandom_range(0, 15) != 0) begin
        case (sb.phase)
          PH_STATUS: begin
            r.mode = MODE_FLASH;
            if (!sb.status_seen) begin
              r.data_byte[SR_BUSY] = ($urandom_range(0, 3) == 0);
              r.data_byte[SR_WEL]  = ($urandom_range(0, 3) != 0);
            end
          end
          PH_RDATA: r.mode = MODE_FLASH;
          PH_WDATA: r.mode = MODE_PAYLOAD;
          default: begin
            r.mode = MODE_FLASH;
            r.data_byte[SR_BUSY] = ($urandom_range(0, 2) == 0);
          end
        endcase
      end
      put_request(r);
    end
  endtask

  task automatic random_sequence();
    flash_req_t r;
    r = rand_req();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        r.mode = MODE_ERASE;
        put_request(r);
        drive_until_idle();
      end
      4, 5, 6: begin
        // Zero or partial-page counts finish at once
        r.mode = $urandom_range(0, 1) ? MODE_READ : MODE_PROG;
        if ($urandom_range(0, 2) == 0) r.byte_count = '0;
        else if (r.byte_count[PAGE_LOG2-1:0] == '0) r.byte_count[0] = 1'b1;
        put_request(r);
      end
      default: begin
        r.mode = 3'($urandom_range(3, 7));
        put_request(r);
      end
    endcase
  endtask

  task automatic random_phase(input int budget);
    int start_n;
    start_n = n_items;
    while (n_items - start_n < budget) random_sequence();
  endtask

  // Stop offering and wait until every owed action has come out
  task automatic wait_for_results();
    int waited;
    waited = 0;
    in_if.valid <= 1'b0;
    while (sb.pending_actions.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic set_fast_read(input bit v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.fast_read = v;
  endtask

  initial begin
    flash_req_t r;
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = 1'b0;
    in_if.valid        = 1'b0;
    in_if.mode         = '0;
    in_if.page_address = '0;
    in_if.byte_count   = '0;
    in_if.sector       = '0;
    in_if.do_erase     = 1'b0;
    in_if.data_byte    = '0;
    quiet              = 1'b0;
    hold_off_req       = 1'b0;
    n_items            = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: length checks, ignored modes, erase polling, status retries
    set_fast_read(1'b0);
    put_request(req_of(MODE_READ, 16'hFFFF, 16'h0000, 8'h00, 1'b0, 8'h00));
    put_request(req_of(MODE_PROG, 16'h0000, 16'h0000, 8'hFF, 1'b1, 8'hFF));
    put_request(req_of(MODE_READ, 16'h1234, 16'hFFFF, 8'h00, 1'b0, 8'h00));
    put_request(req_of(MODE_PROG, 16'h0001, 16'h0080, 8'h00, 1'b0, 8'h00));
    put_request(req_of(3'd5, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 8'hFF));
    put_request(req_of(3'd6, 16'h0000, 16'h0100, 8'h00, 1'b0, 8'h00));
    put_request(req_of(3'd7, 16'hFFFF, 16'h0100, 8'hFF, 1'b1, 8'hFF));
    put_request(req_of(MODE_PAYLOAD, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'hA5));
    put_request(req_of(MODE_FLASH, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h5A));
    put_request(req_of(MODE_ERASE, 16'h0000, 16'h0000, 8'hFF, 1'b1, 8'h00));
    put_request(req_of(MODE_READ, 16'h0000, 16'h0100, 8'h00, 1'b0, 8'h00));
    put_request(req_of(MODE_PAYLOAD, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h11));
    put_request(req_of(MODE_FLASH, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h01));
    put_request(req_of(MODE_FLASH, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'hFE));
    put_request(req_of(MODE_ERASE, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h00));
    put_request(req_of(MODE_FLASH, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h00));
    put_request(req_of(MODE_PROG, 16'hFFFF, 16'h0100, 8'h00, 1'b0, 8'h00));
    put_request(req_of(MODE_FLASH, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h01));
    put_request(req_of(MODE_FLASH, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h00));
    put_request(req_of(MODE_FLASH, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h00));
    put_request(req_of(MODE_FLASH, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'hFF));
    put_request(req_of(MODE_FLASH, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h02));
    put_request(req_of(MODE_FLASH, 16'h0000, 16'h0000, 8'h00, 1'b0, 8'h02));
    drive_until_idle();
    wait_for_results();

    // Fast reads: two pages that wrap the 24-bit address, long output hold-off
    set_fast_read(1'b1);
    put_request(req_of(MODE_READ, 16'hFFFF, 16'h0200, 8'h00, 1'b0, 8'h00));
    hold_off_req = 1'b1;
    drive_until_idle();
    random_phase(PHASE_BUDGET);
    wait_for_results();

    // Status wait and page pause before and after reads
    set_fast_read(1'b0);
    r = rand_req();
    r.mode = MODE_READ;
    r.byte_count = 16'h0100;
    put_request(r);
    drive_until_idle();
    random_phase(PHASE_BUDGET);
    wait_for_results();

    // Last stretch runs without idling on either side
    set_fast_read(1'b1);
    quiet = 1'b1;
    r = rand_req();
    r.mode = MODE_PROG;
    r.byte_count = 16'h0100;
    put_request(r);
    drive_until_idle();
    random_phase(PHASE_BUDGET);
    wait_for_results();

    if (sb.pending_actions.size() != 0)
      sb.log_error($sformatf("%0d expected actions never arrived",
                             sb.pending_actions.size()));
    if (sb.errors == 0) begin
      $display("** spi_nor_flash_command_sequencer: PASSED **");
    end else begin
      $display("** spi_nor_flash_command_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/snfcs_pkg.sv
hw/rtl/snfcs_in_if.sv
hw/rtl/snfcs_out_if.sv
hw/rtl/spi_nor_flash_command_sequencer.sv
bench/spi_nor_flash_command_sequencer_tb.sv
